[rtl/mtg_pkg.sv]
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types and constants of the 32-bit twister word generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    // Store geometry
    localparam int unsigned MT_DEPTH = 624;
    localparam int unsigned MT_SHIFT = 397;

    typedef logic [31:0] t_word;
    typedef logic [9:0]  t_addr;

    // Twist, tempering and seeding constants
    localparam t_word MT_MATRIX       = 32'h9908_b0df;
    localparam t_word MT_UPPER        = 32'h8000_0000;
    localparam t_word MT_LOWER        = 32'h7fff_ffff;
    localparam t_word MT_TEMPER_B     = 32'h9d2c_5680;
    localparam t_word MT_TEMPER_C     = 32'hefc6_0000;
    localparam t_word MT_INIT_MUL     = 32'd1812433253;
    localparam t_word MT_DEFAULT_SEED = 32'd5489;

    localparam t_addr ADDR_LAST  = t_addr'(MT_DEPTH - 1);
    localparam t_addr ADDR_SHIFT = t_addr'(MT_SHIFT);
    localparam t_addr ADDR_DEPTH = t_addr'(MT_DEPTH);

    // Command passed from the front end to the back end
    typedef struct packed {
        logic fill;
    } t_cmd;

endpackage

[rtl/mtg_if.sv]
// ----------------------------------------------------------------------------
// mtg_if
// Valid/ready channels of the generator: request channel and word channel.
// ----------------------------------------------------------------------------
interface mtg_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink   (input valid, input reseed, output ready);
endinterface

interface mtg_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

[rtl/mtg_ram.sv]
// ----------------------------------------------------------------------------
// mtg_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mtg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/mtg_front.sv]
// ----------------------------------------------------------------------------
// mtg_front
// Request front end: takes requests and marks those that need a store fill.
// ----------------------------------------------------------------------------
module mtg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtg_req_if.sink       i_req,
    input  logic          i_full,
    output logic          o_push,
    output mtg_pkg::t_cmd o_cmd
);

    import mtg_pkg::*;

    logic r_seeded;
    logic n_seeded;

    // Take a request whenever the queue has room
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // Fill on explicit reseed or on the first request after reset
    assign o_cmd.fill = i_req.reseed || !r_seeded;

    assign n_seeded = r_seeded || o_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
        end else begin
            r_seeded <= n_seeded;
        end
    end

endmodule

[rtl/mtg_queue.sv]
// ----------------------------------------------------------------------------
// mtg_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mtg_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtg_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mtg_pkg::t_cmd o_cmd
);

    import mtg_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/mtg_back.sv]
// ----------------------------------------------------------------------------
// mtg_back
// Back end: fills the state store, twists one word per draw and tempers it.
// ----------------------------------------------------------------------------
module mtg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_seed,
    input  logic          i_empty,
    input  mtg_pkg::t_cmd i_cmd,
    output logic          o_pop,
    mtg_word_if.source    o_word
);

    import mtg_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_FILL_START = 3'd1;
    localparam logic [2:0] S_FILL_MUL   = 3'd2;
    localparam logic [2:0] S_FILL_WR    = 3'd3;
    localparam logic [2:0] S_DRAW_RD    = 3'd4;
    localparam logic [2:0] S_DRAW_TW    = 3'd5;

    function automatic t_word temper(input t_word v);
        t_word y;
        y = v;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [2:0] r_state, n_state;
    t_addr      r_idx, n_idx;
    t_addr      r_pos, n_pos;
    t_word      r_x, n_x;
    t_word      r_prod, n_prod;
    t_word      r_cur, n_cur;
    logic       r_out_valid, n_out_valid;
    t_word      r_out_word, n_out_word;

    logic       ram_we;
    t_addr      ram_waddr;
    t_word      ram_wdata;
    logic       ram_re;
    t_word      rdata_next;
    t_word      rdata_far;

    t_addr      pos_next;
    t_addr      pos_far_raw;
    t_addr      pos_far;
    t_word      fill_word;
    t_word      twist_y;
    t_word      twist_w;
    logic       out_free;

    mtg_ram #(
        .WIDTH (32),
        .DEPTH (MT_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (pos_next),
        .i_raddr_b (pos_far),
        .o_rdata_a (rdata_next),
        .o_rdata_b (rdata_far)
    );

    // Neighbour addresses of the current position
    assign pos_next    = (r_pos == ADDR_LAST) ? '0 : r_pos + 1'b1;
    assign pos_far_raw = r_pos + ADDR_SHIFT;
    assign pos_far     = (pos_far_raw >= ADDR_DEPTH) ? pos_far_raw - ADDR_DEPTH : pos_far_raw;

    // Seeding recurrence and twist datapath
    assign fill_word = r_prod + {22'd0, r_idx};
    assign twist_y   = (r_cur & MT_UPPER) | (rdata_next & MT_LOWER);
    assign twist_w   = rdata_far ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : '0);
    assign out_free  = !r_out_valid || o_word.ready;

    assign o_word.valid       = r_out_valid;
    assign o_word.random_word = r_out_word;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_x         = r_x;
        n_prod      = r_prod;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = twist_w;
        ram_re      = 1'b0;

        // Drop the result once it is transferred
        if (r_out_valid && o_word.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_cmd.fill ? S_FILL_START : S_DRAW_RD;
                end
            end
            S_FILL_START: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = i_seed;
                n_x       = i_seed ^ (i_seed >> 30);
                n_cur     = i_seed;
                n_idx     = t_addr'(1);
                n_state   = S_FILL_MUL;
            end
            S_FILL_MUL: begin
                n_prod  = r_x * MT_INIT_MUL;
                n_state = S_FILL_WR;
            end
            S_FILL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = fill_word;
                n_x       = fill_word ^ (fill_word >> 30);
                if (r_idx == ADDR_LAST) begin
                    n_pos   = '0;
                    n_state = S_DRAW_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FILL_MUL;
                end
            end
            S_DRAW_RD: begin
                ram_re  = 1'b1;
                n_state = S_DRAW_TW;
            end
            S_DRAW_TW: begin
                // Hold the twist until the output register is free
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_pos;
                    ram_wdata   = twist_w;
                    n_out_valid = 1'b1;
                    n_out_word  = temper(twist_w);
                    n_cur       = rdata_next;
                    n_pos       = pos_next;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_x        <= n_x;
        r_prod     <= n_prod;
        r_cur      <= n_cur;
        r_out_word <= n_out_word;
    end

endmodule

[rtl/mersenne_twister_generator_unit.sv]
// ----------------------------------------------------------------------------
// mersenne_twister_generator_unit
// 32-bit twister random word generator with request queue and fill sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  : request channel; each transfer asks for one word. reseed = 1
//            refills the 624-word store from the seed register first.
//   o_word : word channel; one tempered 32-bit word per request, in order.
//   i_seed_we / i_seed_wdata : seed register write, taken at the clock edge
//            where the write enable is high; used at the next store fill.
// Draw and fill sequence:
//   A plain draw passes the back-end steps queue pop, store read, and
//   twist with write back; the tempered word then goes to the output
//   register. A new request is popped only once the last twist is written
//   back, paced by the sequencer around the store RAM's registered read.
//   A fill (first request after reset, or reseed) writes the seed, then a
//   32x32 multiply step and a write step for each of the other 623 words.
// Reset: synchronous, active low; the seed returns to 5489 and the store is
//   marked unseeded. The store itself is not cleared.
// Stall: while o_word is held, the output register keeps its word, the back
//   end waits and the request queue takes up to QUEUE_DEPTH more requests.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtg_req_if.sink     i_req,
    mtg_word_if.source  o_word,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_wdata
);

    import mtg_pkg::*;

    t_word r_seed;
    t_cmd  push_cmd;
    t_cmd  pop_cmd;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= MT_DEFAULT_SEED;
        end else if (i_seed_we) begin
            r_seed <= i_seed_wdata;
        end
    end

    mtg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    mtg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (pop_cmd)
    );

    mtg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (r_seed),
        .i_empty (empty),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_word  (o_word)
    );

endmodule
